@@ sv/n_queens_first_solution_search_top_macros.svh @@
// Assertion macros for the N-queens search block.
`ifndef N_QUEENS_FIRST_SOLUTION_SEARCH_TOP_MACROS_SVH
`define N_QUEENS_FIRST_SOLUTION_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/nqs_pkg.sv @@
// Package with constants and types for the N-queens search block.
`default_nettype none

package nqs_pkg;

   localparam int MAX_N_DEFAULT = 16;

   localparam int BOARD_W = 5;
   localparam int COL_OUT_W = 4;
   localparam int ROW_OUT_W = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BACK,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_FAIL
   } state_type;

endpackage

`default_nettype wire

@@ sv/nqs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module nqs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/n_queens_first_solution_search_top.sv @@
// Top level of the N-queens first-solution search block.
`default_nettype none

// Each request beat carries a board size N. The block runs a depth-first
// backtracking search over columns 0..N-1, trying rows in ascending order,
// and answers with N result beats (column, row of its queen, solved=1), tlast
// on column N-1. When no placement exists (N=2 or 3), or N is 0 or above
// MAX_N, it answers with one beat of column 0, row 0, solved=0, tlast=1.
// Row and diagonal occupancy live in bitmap registers; the queen row of each
// column lives in a RAM with a registered read. Each row test is a scan step;
// a backtrack step is the failed column, which reads the previous queen from
// the RAM, then the lift of it; a result beat is a RAM read, then an output
// load that waits for a free output. The count of row tests depends on N and
// is in the thousands to tens of thousands for N near 16. One board is
// searched at a time; req_tready is high while no search or answer is under
// way, and the output register lets a new board enter while the final result
// beat still waits to be taken. No clearing pass is needed after reset.
module n_queens_first_solution_search_top
   import nqs_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [4:0] board_size, [7:5] zero
   // Result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [3:0] column_index, [7:4] row_index
   output logic                       rsp_tuser,  // [0] solved
   output logic                       rsp_tlast   // last_result
);

   `include "n_queens_first_solution_search_top_macros.svh"

   localparam int ROW_W = $clog2(MAX_N);
   localparam int CNT_W = $clog2(MAX_N + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int DIAG_N = 2 * MAX_N - 1;
   localparam int DIDX_W = $clog2(DIAG_N);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [MAX_N-1:0]  row_taken_ff, row_taken_in;
   logic [DIAG_N-1:0] rise_ff, rise_in;
   logic [DIAG_N-1:0] fall_ff, fall_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic                 rsp_solved_ff, rsp_solved_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BOARD_W-1:0] req_board;
   logic               req_fire;
   logic               board_bad;
   logic               out_free;

   // Shared toggle / test unit
   logic [CNT_W-1:0]  tog_row;
   logic [CNT_W-1:0]  tog_col;
   logic [SUM_W-1:0]  rise_sum;
   logic [SUM_W-1:0]  fall_sum;
   logic [DIDX_W-1:0] rise_idx;
   logic [DIDX_W-1:0] fall_idx;
   logic [ROW_W-1:0]  row_idx;
   logic              cell_free;
   logic [MAX_N-1:0]  row_mask;
   logic [DIAG_N-1:0] rise_mask;
   logic [DIAG_N-1:0] fall_mask;

   logic             row_in_range;
   logic             col_is_last;
   logic [CNT_W-1:0] col_prev;

   // RAM ports
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [ROW_W-1:0] ram_rd_addr;
   logic [ROW_W-1:0] ram_rd_data;

   // FSM outputs
   logic do_start;
   logic do_place;
   logic do_step;
   logic do_back;
   logic do_emit;
   logic do_fail;

   assign req_board = req_tdata[BOARD_W-1:0];
   assign req_fire  = req_tvalid && req_tready;
   assign board_bad = (req_board == '0) || (32'(req_board) > MAX_N);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign row_in_range = row_ff < n_ff;
   assign col_is_last  = (col_ff + CNT_W'(1)) == n_ff;
   assign col_prev     = col_ff - CNT_W'(1);

   // Pick the cell to test or toggle: the scan cell, or the queen being lifted
   always_comb begin
      if (state_ff == ST_BACK) begin
         tog_row = CNT_W'(ram_rd_data);
         tog_col = col_prev;
      end else begin
         tog_row = row_ff;
         tog_col = col_ff;
      end
   end

   assign rise_sum = SUM_W'(tog_row) + SUM_W'(tog_col);
   assign fall_sum = SUM_W'(tog_row) + SUM_W'(n_ff) - SUM_W'(1) - SUM_W'(tog_col);
   assign rise_idx = rise_sum[DIDX_W-1:0];
   assign fall_idx = fall_sum[DIDX_W-1:0];
   assign row_idx  = tog_row[ROW_W-1:0];

   assign cell_free = !row_taken_ff[row_idx] && !rise_ff[rise_idx] && !fall_ff[fall_idx];

   assign row_mask  = MAX_N'(1) << row_idx;
   assign rise_mask = DIAG_N'(1) << rise_idx;
   assign fall_mask = DIAG_N'(1) << fall_idx;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = board_bad ? ST_FAIL : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (row_in_range) begin
               if (cell_free && col_is_last) begin
                  state_in = ST_EMIT_RD;
               end
            end else if (col_ff == '0) begin
               state_in = ST_FAIL;
            end else begin
               state_in = ST_BACK;
            end
         end
         ST_BACK: begin
            state_in = ST_SCAN;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               state_in = col_is_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready  = 1'b0;
      do_start    = 1'b0;
      do_place    = 1'b0;
      do_step     = 1'b0;
      do_back     = 1'b0;
      do_emit     = 1'b0;
      do_fail     = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = col_ff[ROW_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            do_start   = req_fire && !board_bad;
         end
         ST_SCAN: begin
            if (row_in_range) begin
               do_place = cell_free;
               do_step  = !cell_free;
            end else if (col_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = col_prev[ROW_W-1:0];
            end
         end
         ST_BACK: begin
            do_back = 1'b1;
         end
         ST_EMIT_RD: begin
            ram_rd_en = 1'b1;
         end
         ST_EMIT_LD: begin
            do_emit = out_free;
         end
         ST_FAIL: begin
            do_fail = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign ram_wr_en = do_place;

   // Search datapath
   always_comb begin
      n_in         = n_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_taken_in = row_taken_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;

      if (do_start) begin
         n_in         = CNT_W'(req_board);
         col_in       = '0;
         row_in       = '0;
         row_taken_in = '0;
         rise_in      = '0;
         fall_in      = '0;
      end
      if (do_place || do_back) begin
         row_taken_in = row_taken_ff ^ row_mask;
         rise_in      = rise_ff ^ rise_mask;
         fall_in      = fall_ff ^ fall_mask;
      end
      if (do_place) begin
         // Advance a column; restart at column 0 for readout once all are placed
         col_in = col_is_last ? '0 : col_ff + CNT_W'(1);
         row_in = '0;
      end
      if (do_step) begin
         row_in = row_ff + CNT_W'(1);
      end
      if (do_back) begin
         // Resume the previous column one row past its lifted queen
         col_in = col_prev;
         row_in = CNT_W'(ram_rd_data) + CNT_W'(1);
      end
      if (do_emit) begin
         col_in = col_ff + CNT_W'(1);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_solved_in = rsp_solved_ff;
      rsp_last_in   = rsp_last_ff;
      if (do_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_col_in    = COL_OUT_W'(col_ff);
         rsp_row_in    = ROW_OUT_W'(ram_rd_data);
         rsp_solved_in = 1'b1;
         rsp_last_in   = col_is_last;
      end else if (do_fail) begin
         rsp_valid_in  = 1'b1;
         rsp_col_in    = '0;
         rsp_row_in    = '0;
         rsp_solved_in = 1'b0;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      row_taken_ff  <= row_taken_in;
      rise_ff       <= rise_in;
      fall_ff       <= fall_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_solved_ff <= rsp_solved_in;
      rsp_last_ff   <= rsp_last_in;
   end

   nqs_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MAX_N)
   ) u_queen_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(col_ff[ROW_W-1:0]),
      .wr_data(row_ff[ROW_W-1:0]),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_solved_ff;
   assign rsp_tlast  = rsp_last_ff;

   // One queen per placed column while searching
   `NQS_ASSERT_NOW(a_rows_match_depth, clock, reset,
      (state_ff == ST_SCAN) || (state_ff == ST_BACK),
      $countones(row_taken_ff) == 32'(col_ff),
      "row bitmap out of step with search depth")

   // The search never runs past the board
   `NQS_ASSERT_NOW(a_col_in_board, clock, reset,
      state_ff == ST_SCAN, col_ff < n_ff,
      "search column beyond board size")

   // An unsolved answer is a single all-zero final beat
   `NQS_ASSERT_NOW(a_unsolved_beat, clock, reset,
      rsp_tvalid && !rsp_tuser, rsp_tlast && (rsp_tdata == '0),
      "malformed unsolved result")

   // A beat that completes an answer returns the block to idle
   `NQS_ASSERT_NEXT(a_last_to_idle, clock, reset,
      do_emit && col_is_last, state_ff == ST_IDLE,
      "block not idle after final result")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for the N-queens search block: random and corner board sizes against a predictor.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nqs_pkg::*;

   localparam int CLK_PERIOD       = 10;
   localparam int BOARD_LIMIT      = MAX_N_DEFAULT;
   localparam int RANDOM_PER_PHASE = 27;
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 64;
   // The watchdog limit must exceed the longest 16-wide search; allow ample slack.
   localparam int QUIET_LIMIT      = 3_000_000;
   localparam int REPORT_LIMIT     = 10;

   // One result beat as the block presents it.
   typedef struct packed {
      logic [COL_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0] row;
      logic                 solved;
      logic                 last_flag;
   } placement_type;

   // Predicts the placements for each accepted board and checks result beats.
   class queen_placement_book;
      placement_type        expected_placements[$];
      int                   mismatches;
      logic [ROW_OUT_W-1:0] queen_row[BOARD_LIMIT];
      logic [15:0]          rows_used;
      logic [30:0]          rise_used;
      logic [30:0]          fall_used;
      int                   resume_row[BOARD_LIMIT+1];

      function new();
         mismatches = 0;
         rows_used  = '0;
         rise_used  = '0;
         fall_used  = '0;
         foreach (queen_row[i]) queen_row[i] = '0;
      endfunction

      function bit cell_free(int r, int c, int n);
         return !rows_used[r] && !rise_used[r + c] && !fall_used[r + n - 1 - c];
      endfunction

      function void toggle_cell(int r, int c, int n);
         rows_used[r]             = ~rows_used[r];
         rise_used[r + c]         = ~rise_used[r + c];
         fall_used[r + n - 1 - c] = ~fall_used[r + n - 1 - c];
      endfunction

      // Depth-first search, rows in ascending order; true when all columns hold a queen.
      function bit place_queens(int n);
         int c;
         int r;
         rows_used = '0;
         rise_used = '0;
         fall_used = '0;
         foreach (resume_row[i]) resume_row[i] = 0;
         c = 0;
         while (c >= 0 && c < n) begin
            r = resume_row[c];
            while (r < n && !cell_free(r, c, n)) r++;
            if (r < n) begin
               queen_row[c] = r[ROW_OUT_W-1:0];
               toggle_cell(r, c, n);
               resume_row[c] = r + 1;
               c++;
               resume_row[c] = 0;
            end else begin
               // dead end: lift the previous column's queen and resume past it
               c--;
               if (c >= 0) toggle_cell(int'(queen_row[c]), c, n);
            end
         end
         return c >= n;
      endfunction

      function void note_board(logic [BOARD_W-1:0] board);
         int            n;
         placement_type beat;
         n = int'(board);
         if (n == 0 || n > BOARD_LIMIT || !place_queens(n)) begin
            beat = '{column: '0, row: '0, solved: 1'b0, last_flag: 1'b1};
            expected_placements.push_back(beat);
         end else begin
            for (int k = 0; k < n; k++) begin
               beat.column    = k[COL_OUT_W-1:0];
               beat.row       = queen_row[k];
               beat.solved    = 1'b1;
               beat.last_flag = (k == n - 1);
               expected_placements.push_back(beat);
            end
         end
      endfunction

      function void check_beat(placement_type seen);
         placement_type want;
         if (expected_placements.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result beat col=%0d row=%0d solved=%0b last=%0b",
                        $realtime, seen.column, seen.row, seen.solved, seen.last_flag);
            return;
         end
         want = expected_placements.pop_front();
         if (seen.column !== want.column || seen.row !== want.row ||
             seen.solved !== want.solved || seen.last_flag !== want.last_flag) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result mismatch: expected col=%0d row=%0d solved=%0b last=%0b, %s",
                        $realtime, want.column, want.row, want.solved, want.last_flag,
                        $sformatf("got col=%0d row=%0d solved=%0b last=%0b",
                                  seen.column, seen.row, seen.solved, seen.last_flag));
         end
      endfunction

      function int pending();
         return expected_placements.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int sender_idle_pct = 21;
   int recv_idle_pct   = 62;
   bit hold_rsp        = 1'b0;
   bit hold_done       = 1'b0;
   int quiet_cycles    = 0;

   queen_placement_book book = new();

   // Sizes that hit the corners: trivial board, both unsolvable sizes, every solvable
   // size, empty board, sizes above the limit (all ones included), and the limit itself.
   logic [BOARD_W-1:0] corner_boards[$] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
      5'd11, 5'd12, 5'd13, 5'd0, 5'd17, 5'd31, 5'd30, 5'd16, 5'd15, 5'd14
   };

   always #(CLK_PERIOD / 2) clock = ~clock;

   n_queens_first_solution_search_top #(
      .MAX_N(BOARD_LIMIT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // Weight toward quick searches; keep the slow wide boards rare.
   function automatic logic [BOARD_W-1:0] pick_board();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return 5'($urandom_range(1, 10));
      if (sel < 72) return 5'($urandom_range(11, 13));
      if (sel < 92) return ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      if (sel < 99) return 5'($urandom_range(14, 15));
      return 5'd16;
   endfunction

   // Offer one board beat; enter and leave at a falling edge.
   task automatic send_board(input logic [BOARD_W-1:0] board);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_W - BOARD_W){1'b0}}, board};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Receiver: stall at random; once, with a result waiting, hold off for a long stretch
   // so the output fills and the block stops taking boards.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done && rsp_tvalid === 1'b1) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor both channels at the rising edge; advance the watchdog on quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) book.note_board(req_tdata[BOARD_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            book.check_beat('{column: rsp_tdata[COL_OUT_W-1:0],
                              row: rsp_tdata[COL_OUT_W +: ROW_OUT_W],
                              solved: rsp_tuser, last_flag: rsp_tlast});
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase 1: sender idles lightly, receiver heavily.
      foreach (corner_boards[i]) send_board(corner_boards[i]);
      repeat (RANDOM_PER_PHASE) send_board(pick_board());

      // Phase 2: swap the idle rates.
      sender_idle_pct = 62;
      recv_idle_pct   = 21;
      repeat (RANDOM_PER_PHASE) send_board(pick_board());

      // Phase 3: no idling, plus the one long receiver hold-off.
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      hold_rsp        = 1'b1;
      repeat (RANDOM_PER_PHASE) send_board(pick_board());
      req_tvalid = 1'b0;

      // Drain: wait for every expected beat, then watch for strays.
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (book.mismatches == 0 && book.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
